// ===== hdl/omni_drive_move_and_stop_defines.svh =====
// Assertion macros shared by the omni drive checker.
// Each macro takes a label, the clock, the reset and the two sides of an implication.
`ifndef OMNI_DRIVE_MOVE_AND_STOP_DEFINES_SVH
`define OMNI_DRIVE_MOVE_AND_STOP_DEFINES_SVH

// Same-cycle implication.
`define ODMS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("omni drive check failed");

// Next-cycle implication.
`define ODMS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("omni drive check failed");

`endif

// ===== hdl/odms_pkg.sv =====
// Shared types, constants and the quarter-wave sine table of the omni drive.
// Used by every module of the block but the checker; depends on nothing.
`default_nettype none

package odms_pkg;

  localparam int POSITION_WIDTH = 32;
  localparam int PADDR_W        = 4;
  localparam int DATA_W         = 32;

  // Magnitude of a position as fed to the multiplier; anything wider saturates.
  localparam int ABS_CLIP_W = (POSITION_WIDTH < 33) ? POSITION_WIDTH : 33;
  localparam int MUL_A_W    = (ABS_CLIP_W > 31) ? ABS_CLIP_W : 31;
  localparam int MUL_B_W    = 25;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
  localparam logic [15:0] LEVEL_FULL     = 16'd32768;

  localparam logic [1:0] OP_MOVE   = 2'd0;
  localparam logic [1:0] OP_ROTATE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] REG_DUTY_SCALE  = 2'd0;
  localparam logic [1:0] REG_MM_PER_CNT  = 2'd1;
  localparam logic [1:0] REG_RADIUS      = 2'd2;
  localparam logic [1:0] REG_COUNTER_TOP = 2'd3;

  localparam logic [9:0]  DUTY_SCALE_RST  = 10'd500;
  localparam logic [15:0] MM_PER_CNT_RST  = 16'd1037;
  localparam logic [9:0]  RADIUS_RST      = 10'd115;
  localparam logic [15:0] COUNTER_TOP_RST = 16'd65535;

  localparam logic [9:0] DEG_QUARTER  = 10'd90;
  localparam logic [9:0] DEG_HALF     = 10'd180;
  localparam logic [9:0] DEG_3QUARTER = 10'd270;
  localparam logic [9:0] DEG_TURN     = 10'd360;
  localparam logic [9:0] DEG_TWO_TURN = 10'd720;

  localparam int NUM_WHEELS = 3;
  localparam logic [1:0] LAST_WHEEL = 2'd2;

  typedef logic [9:0] offset_arr_t [0:NUM_WHEELS-1];
  // Heading offsets per wheel: a-60, a-180 and a-300 taken as a+300, a+180, a+60.
  localparam offset_arr_t WHEEL_OFFSET = '{10'd300, 10'd180, 10'd60};

  typedef logic [15:0] sine_tab_t [0:90];

  // Q1.15 sine of whole degrees 0..90 from an odd series to x^11 in Q30.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    int          d;
    for (d = 0; d <= 90; d++) begin
      x    = 64'(d) * 64'(DEG_TO_RAD_Q30);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      r    = (sum + 64'd16384) >> 15;
      if (r > 64'd32768) begin
        r = 64'd32768;
      end
      tab[d] = r[15:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  typedef struct packed {
    logic [9:0]  duty_scale;
    logic [15:0] mm_per_count_q16;
    logic [9:0]  robot_radius_mm;
    logic [15:0] counter_top;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [15:0]       drive_level;
    logic [15:0]       distance_mm;
    logic [9:0]        angle_deg;
    logic              rotate_ccw;
    logic [2:0][15:0]  count;
    logic [2:0]        down;
  } req_t;

  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_op_t;

  typedef struct packed {
    logic [2:0][9:0] duty;
    logic [2:0]      dir;
    logic            stopped;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/odms_regs.sv =====
// APB-style configuration registers of the omni drive.
// Depends on odms_pkg for the register map and the cfg_t bundle.
`default_nettype none

module odms_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [odms_pkg::PADDR_W-1:0] paddr,
  input  logic [odms_pkg::DATA_W-1:0]  pwdata,
  output logic [odms_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output odms_pkg::cfg_t               cfg
);
  import odms_pkg::*;

  logic [1:0] reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_scale       <= DUTY_SCALE_RST;
      cfg.mm_per_count_q16 <= MM_PER_CNT_RST;
      cfg.robot_radius_mm  <= RADIUS_RST;
      cfg.counter_top      <= COUNTER_TOP_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_DUTY_SCALE:  cfg.duty_scale       <= pwdata[9:0];
        REG_MM_PER_CNT:  cfg.mm_per_count_q16 <= pwdata[15:0];
        REG_RADIUS:      cfg.robot_radius_mm  <= pwdata[9:0];
        REG_COUNTER_TOP: cfg.counter_top      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DUTY_SCALE:  prdata = DATA_W'(cfg.duty_scale);
      REG_MM_PER_CNT:  prdata = DATA_W'(cfg.mm_per_count_q16);
      REG_RADIUS:      prdata = DATA_W'(cfg.robot_radius_mm);
      REG_COUNTER_TOP: prdata = DATA_W'(cfg.counter_top);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/odms_mul.sv =====
// Shared multiplier of the omni drive with a registered product.
// Depends on odms_pkg for the operand bundle and widths.
`default_nettype none

module odms_mul (
  input  logic                        clk,
  input  odms_pkg::mul_op_t           mul_op,
  output logic [odms_pkg::PROD_W-1:0] prod
);
  import odms_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_op.a) * PROD_W'(mul_op.b);
  end

endmodule

`default_nettype wire

// ===== hdl/odms_seq.sv =====
// Sequencer and wheel state of the omni drive: steps one request through the
// shared multiplier. Depends on odms_pkg (types, sine table, constants).
`default_nettype none

module odms_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  odms_pkg::cfg_t              cfg,
  input  odms_pkg::req_t              req,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic                        out_free,
  output logic                        res_load,
  output odms_pkg::res_t              res,
  output odms_pkg::mul_op_t           mul_op,
  input  logic [odms_pkg::PROD_W-1:0] prod
);
  import odms_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MV_LVL  = 4'd1;
  localparam logic [3:0] S_MV_DUTY = 4'd2;
  localparam logic [3:0] S_MV_DIST = 4'd3;
  localparam logic [3:0] S_MV_TGT  = 4'd4;
  localparam logic [3:0] S_RT_DUTY = 4'd5;
  localparam logic [3:0] S_RT_RA   = 4'd6;
  localparam logic [3:0] S_RT_K    = 4'd7;
  localparam logic [3:0] S_RT_TGT  = 4'd8;
  localparam logic [3:0] S_TK_POS  = 4'd9;
  localparam logic [3:0] S_TK_ABS  = 4'd10;
  localparam logic [3:0] S_TK_MUL  = 4'd11;
  localparam logic [3:0] S_TK_CMP  = 4'd12;
  localparam logic [3:0] S_TK_END  = 4'd13;
  localparam logic [3:0] S_DONE    = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] wi;
  logic       primed;
  logic       hit;
  logic       stop_flag;

  logic [15:0]               last_count     [0:NUM_WHEELS-1];
  logic [POSITION_WIDTH-1:0] wheel_position [0:NUM_WHEELS-1];
  logic [17:0]               target_travel  [0:NUM_WHEELS-1];
  logic [9:0]                held_duty      [0:NUM_WHEELS-1];
  logic                      held_dir       [0:NUM_WHEELS-1];

  // captured request and per-wheel scratch
  logic [1:0]            op_r;
  logic [15:0]           level_r;
  logic [15:0]           dist_r;
  logic [8:0]            amod_r;
  logic [9:0]            angle_r;
  logic                  ccw_r;
  logic [2:0][15:0]      cnt_r;
  logic [2:0]            down_r;
  logic [15:0]           mag_r;
  logic                  spos_r;
  logic [ABS_CLIP_W-1:0] abs_r;

  logic                      accept;
  logic [15:0]               level_clamp;
  logic [9:0]                amod_full;
  logic [9:0]                ang_sum;
  logic [9:0]                ang_w;
  logic [6:0]                quad_idx;
  logic                      quad_neg;
  logic [15:0]               mag;
  logic                      spos;
  logic [15:0]               cur_cnt;
  logic [15:0]               cur_last;
  logic [17:0]               diff;
  logic [17:0]               period;
  logic [17:0]               delta;
  logic [POSITION_WIDTH-1:0] pos_next;
  logic [POSITION_WIDTH-1:0] pos_cur;
  logic [POSITION_WIDTH-1:0] pos_abs;
  logic [ABS_CLIP_W-1:0]     pos_clip;
  logic [17:0]               tgt_cur;
  logic [17:0]               tgt_abs;
  logic                      travel_hit;
  logic [16:0]               mv_t;
  logic [17:0]               mv_tgt;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign res_load  = (state == S_DONE) && out_free;

  assign level_clamp = (req.drive_level > LEVEL_FULL) ? LEVEL_FULL : req.drive_level;

  always_comb begin
    if (req.angle_deg >= DEG_TWO_TURN) begin
      amod_full = req.angle_deg - DEG_TWO_TURN;
    end else if (req.angle_deg >= DEG_TURN) begin
      amod_full = req.angle_deg - DEG_TURN;
    end else begin
      amod_full = req.angle_deg;
    end
  end

  // wheel heading and quadrant fold into the table
  assign ang_sum = {1'b0, amod_r} + WHEEL_OFFSET[wi];
  assign ang_w   = (ang_sum >= DEG_TURN) ? (ang_sum - DEG_TURN) : ang_sum;

  always_comb begin
    if (ang_w <= DEG_QUARTER) begin
      quad_idx = ang_w[6:0];
      quad_neg = 1'b0;
    end else if (ang_w <= DEG_HALF) begin
      quad_idx = 7'(DEG_HALF - ang_w);
      quad_neg = 1'b0;
    end else if (ang_w <= DEG_3QUARTER) begin
      quad_idx = 7'(ang_w - DEG_HALF);
      quad_neg = 1'b1;
    end else begin
      quad_idx = 7'(DEG_TURN - ang_w);
      quad_neg = 1'b1;
    end
  end

  assign mag  = SINE_TAB[quad_idx];
  assign spos = !quad_neg && (mag != 16'd0);

  // encoder change with wrap at counter_top + 1
  assign cur_cnt  = cnt_r[wi];
  assign cur_last = last_count[wi];
  assign diff     = {2'b00, cur_cnt} - {2'b00, cur_last};
  assign period   = {2'b00, cfg.counter_top} + 18'd1;

  always_comb begin
    if ((cur_cnt > cur_last) && down_r[wi]) begin
      delta = diff - period;
    end else if ((cur_cnt < cur_last) && !down_r[wi]) begin
      delta = diff + period;
    end else begin
      delta = diff;
    end
  end

  assign pos_cur  = wheel_position[wi];
  assign pos_next = pos_cur + {{(POSITION_WIDTH-18){delta[17]}}, delta};
  assign pos_abs  = pos_cur[POSITION_WIDTH-1] ? (~pos_cur + 1'b1) : pos_cur;
  assign pos_clip = (|(pos_abs >> ABS_CLIP_W)) ? '1 : pos_abs[ABS_CLIP_W-1:0];

  assign tgt_cur    = target_travel[wi];
  assign tgt_abs    = tgt_cur[17] ? (~tgt_cur + 1'b1) : tgt_cur;
  assign travel_hit = prod[PROD_W-1:16] > (PROD_W-16)'(tgt_abs);

  assign mv_t   = prod[31:15];
  assign mv_tgt = spos_r ? (18'd0 - {1'b0, mv_t}) : {1'b0, mv_t};

  always_comb begin
    mul_op.a = '0;
    mul_op.b = '0;
    case (state)
      S_MV_LVL: begin
        mul_op.a = MUL_A_W'(level_r);
        mul_op.b = MUL_B_W'(mag);
      end
      S_MV_DUTY: begin
        mul_op.a = MUL_A_W'(prod[30:0]);
        mul_op.b = MUL_B_W'(cfg.duty_scale);
      end
      S_MV_DIST: begin
        mul_op.a = MUL_A_W'(dist_r);
        mul_op.b = MUL_B_W'(mag_r);
      end
      S_RT_DUTY: begin
        mul_op.a = MUL_A_W'(level_r);
        mul_op.b = MUL_B_W'(cfg.duty_scale);
      end
      S_RT_RA: begin
        mul_op.a = MUL_A_W'(cfg.robot_radius_mm);
        mul_op.b = MUL_B_W'(angle_r);
      end
      S_RT_K: begin
        mul_op.a = MUL_A_W'(prod[19:0]);
        mul_op.b = DEG_TO_RAD_Q30;
      end
      S_TK_MUL: begin
        mul_op.a = MUL_A_W'(abs_r);
        mul_op.b = MUL_B_W'(cfg.mm_per_count_q16);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req.op)
            OP_MOVE:   state_next = S_MV_LVL;
            OP_ROTATE: state_next = S_RT_DUTY;
            OP_TICK:   state_next = S_TK_POS;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_MV_LVL:  state_next = S_MV_DUTY;
      S_MV_DUTY: state_next = S_MV_DIST;
      S_MV_DIST: state_next = S_MV_TGT;
      S_MV_TGT:  state_next = (wi == LAST_WHEEL) ? S_DONE : S_MV_LVL;
      S_RT_DUTY: state_next = S_RT_RA;
      S_RT_RA:   state_next = S_RT_K;
      S_RT_K:    state_next = S_RT_TGT;
      S_RT_TGT:  state_next = S_DONE;
      S_TK_POS:  state_next = S_TK_ABS;
      S_TK_ABS:  state_next = S_TK_MUL;
      S_TK_MUL:  state_next = S_TK_CMP;
      S_TK_CMP:  state_next = (wi == LAST_WHEEL) ? S_TK_END : S_TK_POS;
      S_TK_END:  state_next = S_DONE;
      S_DONE:    state_next = out_free ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wi        <= 2'd0;
      primed    <= 1'b0;
      hit       <= 1'b0;
      stop_flag <= 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        last_count[i]     <= '0;
        wheel_position[i] <= '0;
        target_travel[i]  <= '0;
        held_duty[i]      <= '0;
        held_dir[i]       <= 1'b0;
      end
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            wi        <= 2'd0;
            hit       <= 1'b0;
            stop_flag <= 1'b0;
          end
        end
        S_MV_DUTY: held_dir[wi] <= spos_r && (prod != '0);
        S_MV_DIST: held_duty[wi] <= prod[39:30];
        S_MV_TGT: begin
          target_travel[wi] <= mv_tgt;
          wi                <= wi + 2'd1;
        end
        S_RT_RA: begin
          for (int i = 0; i < NUM_WHEELS; i++) begin
            held_duty[i] <= prod[24:15];
            held_dir[i]  <= ccw_r;
          end
        end
        S_RT_TGT: begin
          for (int i = 0; i < NUM_WHEELS; i++) begin
            target_travel[i]  <= prod[47:30];
            wheel_position[i] <= '0;
            last_count[i]     <= '0;
          end
        end
        S_TK_POS: begin
          wheel_position[wi] <= primed ? pos_next : '0;
          last_count[wi]     <= cur_cnt;
        end
        S_TK_CMP: begin
          if (travel_hit) begin
            hit <= 1'b1;
          end
          wi <= wi + 2'd1;
        end
        S_TK_END: begin
          if (hit) begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
              held_duty[i] <= '0;
            end
            primed    <= 1'b0;
            stop_flag <= 1'b1;
          end else begin
            primed <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= req.op;
      level_r <= level_clamp;
      dist_r  <= req.distance_mm;
      amod_r  <= amod_full[8:0];
      angle_r <= req.angle_deg;
      ccw_r   <= req.rotate_ccw;
      cnt_r   <= req.count;
      down_r  <= req.down;
    end
    if (state == S_MV_LVL) begin
      mag_r  <= mag;
      spos_r <= spos;
    end
    if (state == S_TK_ABS) begin
      abs_r <= pos_clip;
    end
  end

  assign res.duty    = {held_duty[2], held_duty[1], held_duty[0]};
  assign res.dir     = {held_dir[2], held_dir[1], held_dir[0]};
  assign res.stopped = stop_flag && (op_r == OP_TICK);

endmodule

`default_nettype wire

// ===== hdl/omni_drive_move_and_stop.sv =====
// Three-wheel omni drive: move, rotate and stop-on-target; top level.
// The sequencer is free for the next request once its result is registered. All products
// run through one registered 32x25 multiplier, one product per cycle. Synchronous reset
// clears control, wheel state and registers to their defaults; no clearing pass. Uses
// odms_pkg.
`default_nettype none

module omni_drive_move_and_stop (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic [15:0]                  drive_level,
  input  logic [15:0]                  distance_mm,
  input  logic [9:0]                   angle_deg,
  input  logic                         rotate_ccw,
  input  logic [15:0]                  count_a,
  input  logic [15:0]                  count_b,
  input  logic [15:0]                  count_c,
  input  logic                         down_a,
  input  logic                         down_b,
  input  logic                         down_c,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [9:0]                   duty_a,
  output logic [9:0]                   duty_b,
  output logic [9:0]                   duty_c,
  output logic                         dir_a,
  output logic                         dir_b,
  output logic                         dir_c,
  output logic                         stopped,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [odms_pkg::PADDR_W-1:0] paddr,
  input  logic [odms_pkg::DATA_W-1:0]  pwdata,
  output logic [odms_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import odms_pkg::*;

  cfg_t                 cfg;
  req_t                 req;
  res_t                 res;
  mul_op_t              mul_op;
  logic [PROD_W-1:0]    prod;
  logic                 out_free;
  logic                 res_load;

  // Bundle the request fields; wheel one sits in lane zero.
  assign req.op          = op;
  assign req.drive_level = drive_level;
  assign req.distance_mm = distance_mm;
  assign req.angle_deg   = angle_deg;
  assign req.rotate_ccw  = rotate_ccw;
  assign req.count       = {count_c, count_b, count_a};
  assign req.down        = {down_c, down_b, down_a};

  odms_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  odms_mul u_mul (
    .clk    (clk),
    .mul_op (mul_op),
    .prod   (prod)
  );

  odms_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .mul_op    (mul_op),
    .prod      (prod)
  );

  // The output register frees the sequencer: a finished result waits here while the
  // next request is already being worked on. Hold the sequencer in its last state only
  // while this register still carries a result nobody has taken.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload needs no reset: it is only looked at while out_valid is high.
  always_ff @(posedge clk) begin
    if (res_load) begin
      duty_a  <= res.duty[0];
      duty_b  <= res.duty[1];
      duty_c  <= res.duty[2];
      dir_a   <= res.dir[0];
      dir_b   <= res.dir[1];
      dir_c   <= res.dir[2];
      stopped <= res.stopped;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/odms_checker.sv =====
// Port-level checks for the omni drive and the bind that attaches them.
// Depends on omni_drive_move_and_stop_defines.svh for the assertion macros.
`default_nettype none
`include "omni_drive_move_and_stop_defines.svh"

module odms_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] duty_a,
  input logic [9:0] duty_b,
  input logic [9:0] duty_c,
  input logic       dir_a,
  input logic       dir_b,
  input logic       dir_c,
  input logic       stopped
);

  // A stalled result stays valid and keeps its duties, dir_a and stopped.
  `ODMS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(duty_a) && $stable(duty_b) && $stable(duty_c) && $stable(dir_a) && $stable(stopped))

  // Accepting a request makes the sequencer busy.
  `ODMS_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // A stop always comes with all drive cut.
  `ODMS_ASSERT_IMP(a_stop_cuts_drive, clk, rst, out_valid && stopped, duty_a == 10'd0 && duty_b == 10'd0 && duty_c == 10'd0)

  // A new result only appears after the sequencer was busy.
  `ODMS_ASSERT_IMP(a_result_from_work, clk, rst, $rose(out_valid), $past(!in_ready))

endmodule

bind omni_drive_move_and_stop odms_checker u_odms_checker (.*);

`default_nettype wire
